// File: rtl/rgbacm_pkg.sv
// Shared constants and types for the RGBA channel mixer.
// No dependencies; imported by every module of the block but rgbacm_checker.
package rgbacm_pkg;

    localparam int REG_BITS      = 32;
    localparam int COEF_BITS     = 16;
    localparam int NUM_REGS      = 8;
    localparam int REG_IDX_BITS  = $clog2(NUM_REGS);
    localparam int CFG_ADDR_BITS = 4;
    localparam int NUM_CH        = 4;
    localparam int NUM_COLORS    = 3;
    localparam int CH_MATTE      = 3;

    typedef logic [REG_BITS-1:0] coef_word_t;

    // identity matrix: 1.0 on the diagonal in Q1.15
    localparam coef_word_t REG_RESET [NUM_REGS] = '{
        32'h0000_8000, 32'h0000_0000,
        32'h8000_0000, 32'h0000_0000,
        32'h0000_0000, 32'h0000_8000,
        32'h0000_0000, 32'h8000_0000
    };

endpackage

// File: rtl/rgbacm_unpremul.sv
// Un-premultiply pipeline: color * MAX / alpha, one quotient bit per stage.
// Depends on rgbacm_pkg.
module rgbacm_unpremul #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  s_valid,
    output logic                                                  s_ready,
    input  logic [rgbacm_pkg::NUM_COLORS-1:0][CHANNEL_BITS-1:0]   s_color,
    input  logic [CHANNEL_BITS-1:0]                               s_matte,
    output logic                                                  m_valid,
    input  logic                                                  m_ready,
    output logic [rgbacm_pkg::NUM_COLORS-1:0][CHANNEL_BITS-1:0]   m_color,
    output logic [CHANNEL_BITS-1:0]                               m_matte
);
    import rgbacm_pkg::*;

    localparam int CB   = CHANNEL_BITS;
    localparam int NST  = CB + 1;
    localparam int LAST = NST - 1;

    typedef logic [CB-1:0] chan_t;

    localparam chan_t CH_MAX = '1;

    logic [NST-1:0] valid_reg;
    logic [NST:0]   adv;

    chan_t rem_reg  [NST][NUM_COLORS];
    chan_t low_reg  [NST][NUM_COLORS];
    chan_t quo_reg  [NST][NUM_COLORS];
    chan_t orig_reg [NST][NUM_COLORS];
    chan_t matte_reg[NST];
    logic [NUM_COLORS-1:0] sat_reg [NST];
    logic [NST-1:0]        zero_reg;

    logic [CB:0]           trial [NST-1][NUM_COLORS];
    logic [NUM_COLORS-1:0] fits  [NST-1];

    // stage j loads when it is empty or its contents move on
    assign adv[NST] = m_ready;
    for (genvar j = 0; j < NST; j++) begin : g_adv
        assign adv[j] = !valid_reg[j] | adv[j+1];
    end
    assign s_ready = adv[0];

    // partial remainder with the next dividend bit shifted in
    always_comb begin
        for (int j = 0; j < NST - 1; j++) begin
            for (int c = 0; c < NUM_COLORS; c++) begin
                trial[j][c] = {rem_reg[j][c], low_reg[j][c][CB-1]};
                fits[j][c]  = trial[j][c] >= {1'b0, matte_reg[j]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int j = 1; j < NST; j++) begin
                if (adv[j]) begin
                    valid_reg[j] <= valid_reg[j-1];
                end
            end
        end
    end

    // dividend c*MAX = (c << CB) - c: high half c-1, low half -c
    always_ff @(posedge aclk) begin
        if (adv[0] && s_valid) begin
            for (int c = 0; c < NUM_COLORS; c++) begin
                orig_reg[0][c] <= s_color[c];
                rem_reg[0][c]  <= (s_color[c] == '0) ? '0 : s_color[c] - chan_t'(1);
                low_reg[0][c]  <= chan_t'(0) - s_color[c];
                quo_reg[0][c]  <= '0;
                sat_reg[0][c]  <= s_color[c] >= s_matte;
            end
            matte_reg[0] <= s_matte;
            zero_reg[0]  <= s_matte == '0;
        end
        for (int j = 1; j < NST; j++) begin
            if (adv[j] && valid_reg[j-1]) begin
                for (int c = 0; c < NUM_COLORS; c++) begin
                    rem_reg[j][c]  <= fits[j-1][c]
                                    ? chan_t'(trial[j-1][c] - {1'b0, matte_reg[j-1]})
                                    : trial[j-1][c][CB-1:0];
                    low_reg[j][c]  <= {low_reg[j-1][c][CB-2:0], 1'b0};
                    quo_reg[j][c]  <= {quo_reg[j-1][c][CB-2:0], fits[j-1][c]};
                    orig_reg[j][c] <= orig_reg[j-1][c];
                    sat_reg[j][c]  <= sat_reg[j-1][c];
                end
                matte_reg[j] <= matte_reg[j-1];
                zero_reg[j]  <= zero_reg[j-1];
            end
        end
    end

    // zero alpha passes the color through; color at or above alpha saturates
    always_comb begin
        for (int c = 0; c < NUM_COLORS; c++) begin
            if (zero_reg[LAST]) begin
                m_color[c] = orig_reg[LAST][c];
            end else if (sat_reg[LAST][c]) begin
                m_color[c] = CH_MAX;
            end else begin
                m_color[c] = quo_reg[LAST][c];
            end
        end
    end

    assign m_valid = valid_reg[LAST];
    assign m_matte = matte_reg[LAST];

endmodule

// File: rtl/rgba_channel_mixer.sv
// Top level of the RGBA channel mixer: config registers, 4x4 mix, re-premultiply.
// Depends on rgbacm_pkg and rgbacm_unpremul.
//
// Takes one premultiplied RGBA pixel per clock and returns one per clock unless the output
// is stalled by m_ready. The un-premultiply divider resolves one quotient bit per stage,
// followed by one stage of sixteen coefficient products, one of sums and clamping, one
// multiply by the new alpha, and two for the divide by the channel maximum. Every stage
// holds its own valid bit, so bubbles are squeezed out under back-pressure. Coefficient
// registers are written through the cfg port and should only change while no pixel is in
// flight.
module rgba_channel_mixer #(
    parameter int CHANNEL_BITS   = 8,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [rgbacm_pkg::CFG_ADDR_BITS-1:0] cfg_index,
    input  logic [rgbacm_pkg::REG_BITS-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [CHANNEL_BITS-1:0]              s_in_red,
    input  logic [CHANNEL_BITS-1:0]              s_in_green,
    input  logic [CHANNEL_BITS-1:0]              s_in_blue,
    input  logic [CHANNEL_BITS-1:0]              s_in_matte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [CHANNEL_BITS-1:0]              m_out_red,
    output logic [CHANNEL_BITS-1:0]              m_out_green,
    output logic [CHANNEL_BITS-1:0]              m_out_blue,
    output logic [CHANNEL_BITS-1:0]              m_out_matte
);
    import rgbacm_pkg::*;

    localparam int CB     = CHANNEL_BITS;
    localparam int PROD_W = CB + COEF_BITS;
    localparam int ACC_W  = PROD_W + 2;
    localparam int X_W    = 2 * CB;
    localparam int NSTG   = 5;

    typedef logic [CB-1:0] chan_t;

    localparam chan_t            CH_MAX = '1;
    localparam logic [X_W-1:0]   HALF   = X_W'((2 ** (CB - 1)) - 1);
    localparam logic [X_W:0]     DIVV   = (X_W + 1)'(CH_MAX);

    coef_word_t coef_reg [NUM_REGS];

    logic                                    div_valid;
    logic                                    div_ready;
    logic [NUM_COLORS-1:0][CB-1:0]           div_color;
    chan_t                                   div_matte;

    chan_t                  chan [NUM_CH];
    logic [COEF_BITS-1:0]   coef [NUM_CH][NUM_CH];
    logic [ACC_W-1:0]       acc  [NUM_CH];
    logic [ACC_W-1:0]       acc_int [NUM_CH];
    logic [X_W:0]           est_sum [NUM_COLORS];
    logic [X_W:0]           rem     [NUM_COLORS];

    logic [NSTG-1:0]        vld_reg;
    logic [NSTG:0]          adv;

    logic [PROD_W-1:0]      prod_reg [NUM_CH][NUM_CH];
    chan_t                  mix_reg  [NUM_CH];
    logic [X_W-1:0]         x_reg    [NUM_COLORS];
    logic [X_W-1:0]         x4_reg   [NUM_COLORS];
    logic [CB:0]            qe_reg   [NUM_COLORS];
    chan_t                  out_reg  [NUM_COLORS];
    chan_t                  matte3_reg;
    chan_t                  matte4_reg;
    chan_t                  matte5_reg;

    // configuration writes; indexes past the register list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                coef_reg[k] <= REG_RESET[k];
            end
        end else if (cfg_wr_en && (cfg_index < CFG_ADDR_BITS'(NUM_REGS))) begin
            coef_reg[cfg_index[REG_IDX_BITS-1:0]] <= cfg_wdata;
        end
    end

    rgbacm_unpremul #(
        .CHANNEL_BITS(CB)
    ) u_unpremul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_color({s_in_blue, s_in_green, s_in_red}),
        .s_matte(s_in_matte),
        .m_valid(div_valid),
        .m_ready(div_ready),
        .m_color(div_color),
        .m_matte(div_matte)
    );

    // two coefficients per register: low half for the even input channel
    always_comb begin
        for (int i = 0; i < NUM_COLORS; i++) begin
            chan[i] = div_color[i];
        end
        chan[CH_MATTE] = div_matte;
        for (int o = 0; o < NUM_CH; o++) begin
            for (int i = 0; i < NUM_CH; i++) begin
                if (i % 2 == 0) begin
                    coef[o][i] = coef_reg[2 * o + i / 2][COEF_BITS-1:0];
                end else begin
                    coef[o][i] = coef_reg[2 * o + i / 2][REG_BITS-1:COEF_BITS];
                end
            end
        end
    end

    assign adv[NSTG] = m_ready;
    for (genvar j = 0; j < NSTG; j++) begin : g_adv
        assign adv[j] = !vld_reg[j] | adv[j+1];
    end
    assign div_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= div_valid;
            end
            for (int j = 1; j < NSTG; j++) begin
                if (adv[j]) begin
                    vld_reg[j] <= vld_reg[j-1];
                end
            end
        end
    end

    // sums, fixed-point truncation and clamp; divide-by-MAX estimate and fixup
    always_comb begin
        for (int o = 0; o < NUM_CH; o++) begin
            acc[o] = ACC_W'(prod_reg[o][0]) + ACC_W'(prod_reg[o][1])
                   + ACC_W'(prod_reg[o][2]) + ACC_W'(prod_reg[o][3]);
            acc_int[o] = acc[o] >> COEF_FRAC_BITS;
        end
        // (x + x/2^CB) / 2^CB undershoots x/MAX by at most one
        for (int k = 0; k < NUM_COLORS; k++) begin
            est_sum[k] = {1'b0, x_reg[k]} + (X_W + 1)'(x_reg[k] >> CB);
            rem[k]     = {1'b0, x4_reg[k]} + (X_W + 1)'(qe_reg[k])
                       - {qe_reg[k], {CB{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0] && div_valid) begin
            for (int o = 0; o < NUM_CH; o++) begin
                for (int i = 0; i < NUM_CH; i++) begin
                    prod_reg[o][i] <= PROD_W'(chan[i]) * PROD_W'(coef[o][i]);
                end
            end
        end
        if (adv[1] && vld_reg[0]) begin
            for (int o = 0; o < NUM_CH; o++) begin
                mix_reg[o] <= (acc_int[o] > ACC_W'(CH_MAX)) ? CH_MAX : acc_int[o][CB-1:0];
            end
        end
        if (adv[2] && vld_reg[1]) begin
            for (int k = 0; k < NUM_COLORS; k++) begin
                x_reg[k] <= X_W'(mix_reg[k]) * X_W'(mix_reg[CH_MATTE]) + HALF;
            end
            matte3_reg <= mix_reg[CH_MATTE];
        end
        if (adv[3] && vld_reg[2]) begin
            for (int k = 0; k < NUM_COLORS; k++) begin
                qe_reg[k] <= est_sum[k][X_W:CB];
                x4_reg[k] <= x_reg[k];
            end
            matte4_reg <= matte3_reg;
        end
        if (adv[4] && vld_reg[3]) begin
            for (int k = 0; k < NUM_COLORS; k++) begin
                out_reg[k] <= CB'(qe_reg[k] + (CB + 1)'(rem[k] >= DIVV));
            end
            matte5_reg <= matte4_reg;
        end
    end

    assign m_valid     = vld_reg[NSTG-1];
    assign m_out_red   = out_reg[0];
    assign m_out_green = out_reg[1];
    assign m_out_blue  = out_reg[2];
    assign m_out_matte = matte5_reg;

endmodule

// File: rtl/rgbacm_checker.sv
// Port-level checks for the RGBA channel mixer, bound to the top level.
// Depends on rgba_channel_mixer (bind target).
module rgbacm_checker #(
    parameter int CHANNEL_BITS = 8
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [CHANNEL_BITS-1:0] m_out_red,
    input logic [CHANNEL_BITS-1:0] m_out_green,
    input logic [CHANNEL_BITS-1:0] m_out_blue,
    input logic [CHANNEL_BITS-1:0] m_out_matte
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red) && $stable(m_out_green)
                                && $stable(m_out_blue) && $stable(m_out_matte))
        else $error("result changed while stalled");

    // premultiplied colors never exceed their alpha
    a_premul_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_red <= m_out_matte && m_out_green <= m_out_matte
                    && m_out_blue <= m_out_matte)
        else $error("color above alpha at output");

    // with the output stage empty the pipeline cannot be blocking requests
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rgba_channel_mixer rgbacm_checker #(
    .CHANNEL_BITS(CHANNEL_BITS)
) u_rgbacm_checker (.*);

// File: tb/sv/rgbacm_mix_checker.sv
// Scoreboard for the RGBA channel mixer: snoops the cfg port, predicts each output pixel.
// Depends on rgbacm_pkg; instantiated beside the DUT by tb_rgba_channel_mixer.
module rgbacm_mix_checker #(
    parameter int CHANNEL_BITS   = 8,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [rgbacm_pkg::CFG_ADDR_BITS-1:0] cfg_index,
    input  logic [rgbacm_pkg::REG_BITS-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [CHANNEL_BITS-1:0]              s_in_red,
    input  logic [CHANNEL_BITS-1:0]              s_in_green,
    input  logic [CHANNEL_BITS-1:0]              s_in_blue,
    input  logic [CHANNEL_BITS-1:0]              s_in_matte,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [CHANNEL_BITS-1:0]              m_out_red,
    input  logic [CHANNEL_BITS-1:0]              m_out_green,
    input  logic [CHANNEL_BITS-1:0]              m_out_blue,
    input  logic [CHANNEL_BITS-1:0]              m_out_matte,
    output int                                   mismatches,
    output int                                   in_flight
);
    timeunit 1ns;
    timeprecision 1ps;
    import rgbacm_pkg::*;

    localparam longint unsigned CH_MAX = (64'd1 << CHANNEL_BITS) - 64'd1;
    localparam int MAX_PRINTED = 100;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    // index 0 red, 1 green, 2 blue, CH_MATTE matte; same order as the register rows
    typedef logic [NUM_CH-1:0][CHANNEL_BITS-1:0] pixel_t;

    coef_word_t coefs [NUM_REGS];
    pixel_t     expected_pixels [$];
    int         results_seen = 0;

    task automatic report(input string what);
        if (mismatches < MAX_PRINTED)
            $display("%m: %s", what);
        mismatches++;
    endtask

    function automatic chan_t restore_color(input chan_t c, input chan_t a);
        longint unsigned cw, aw, q;
        cw = 64'(c);
        aw = 64'(a);
        q = cw * CH_MAX / aw;
        return (q > CH_MAX) ? chan_t'(CH_MAX) : chan_t'(q);
    endfunction

    // row k of the matrix lives in registers 2k (red, green) and 2k+1 (blue, matte)
    function automatic longint unsigned mix_row(input pixel_t lin, input int k);
        longint unsigned acc, chv, coef;
        coef_word_t word;
        acc = '0;
        for (int j = 0; j < NUM_CH; j++) begin
            word = coefs[2*k + j/2];
            coef = (j % 2) ? 64'(word[REG_BITS-1:COEF_BITS]) : 64'(word[COEF_BITS-1:0]);
            chv = 64'(lin[j]);
            acc += chv * coef;
        end
        acc = acc >> COEF_FRAC_BITS;
        return (acc > CH_MAX) ? CH_MAX : acc;
    endfunction

    function automatic pixel_t predict_pixel(input pixel_t px);
        pixel_t lin, res;
        longint unsigned mixed [NUM_CH];
        lin = px;
        // zero alpha: colors go into the mix untouched
        if (px[CH_MATTE] != '0) begin
            for (int j = 0; j < NUM_COLORS; j++)
                lin[j] = restore_color(px[j], px[CH_MATTE]);
        end
        for (int k = 0; k < NUM_CH; k++)
            mixed[k] = mix_row(lin, k);
        res[CH_MATTE] = chan_t'(mixed[CH_MATTE]);
        for (int k = 0; k < NUM_COLORS; k++)
            res[k] = chan_t'((mixed[k] * mixed[CH_MATTE] + CH_MAX / 2) / CH_MAX);
        return res;
    endfunction

    always @(posedge aclk) begin
        pixel_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++)
                coefs[i] <= REG_RESET[i];
            expected_pixels.delete();
            in_flight <= 0;
        end else begin
            if (cfg_wr_en && cfg_index < CFG_ADDR_BITS'(NUM_REGS))
                coefs[cfg_index[REG_IDX_BITS-1:0]] <= cfg_wdata;
            if (s_valid && s_ready)
                expected_pixels.push_back(
                    predict_pixel({s_in_matte, s_in_blue, s_in_green, s_in_red}));
            if (m_valid && m_ready) begin
                got = {m_out_matte, m_out_blue, m_out_green, m_out_red};
                if (expected_pixels.size() == 0) begin
                    report($sformatf("output pixel %0d with no request pending", results_seen));
                end else begin
                    want = expected_pixels.pop_front();
                    for (int k = 0; k < NUM_CH; k++)
                        if (got[k] !== want[k])
                            report($sformatf("pixel %0d channel %0d: got %0d, want %0d",
                                             results_seen, k, got[k], want[k]));
                end
                results_seen++;
            end
            in_flight <= expected_pixels.size();
        end
    end

endmodule

// File: tb/sv/tb_rgba_channel_mixer.sv
// Top of the RGBA channel mixer testbench: clock, reset, cfg writes, pixel stimulus.
// Depends on rgbacm_pkg, rgba_channel_mixer and rgbacm_mix_checker.
module tb_rgba_channel_mixer;
    timeunit 1ns;
    timeprecision 1ps;
    import rgbacm_pkg::*;

    localparam int CH_BITS      = 8;
    localparam int FRAC_BITS    = 15;
    localparam int RUN_LIMIT    = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 180;
    localparam int NUM_DIRECTED = 12;
    localparam logic [REG_BITS-1:0] COEF_ONE = 32'h0000_8000;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_RED_RG, REG_RED_BM, REG_GREEN_RG, REG_GREEN_BM,
        REG_BLUE_RG, REG_BLUE_BM, REG_MATTE_RG, REG_MATTE_BM
    } mix_reg_e;

    typedef enum int {
        MAT_ZERO, MAT_FULL, MAT_RANDOM, MAT_UNIT_RANGE, MAT_IDENTITY, MAT_SWAP_RB
    } matrix_kind_e;
    localparam int NUM_KINDS = 6;

    logic                     aclk       = 1'b0;
    logic                     aresetn    = 1'b0;
    logic                     cfg_wr_en  = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_index  = '0;
    logic [REG_BITS-1:0]      cfg_wdata  = '0;
    logic                     s_valid    = 1'b0;
    logic                     s_ready;
    logic [CH_BITS-1:0]       s_in_red   = '0;
    logic [CH_BITS-1:0]       s_in_green = '0;
    logic [CH_BITS-1:0]       s_in_blue  = '0;
    logic [CH_BITS-1:0]       s_in_matte = '0;
    logic                     m_valid;
    logic                     m_ready    = 1'b0;
    logic [CH_BITS-1:0]       m_out_red;
    logic [CH_BITS-1:0]       m_out_green;
    logic [CH_BITS-1:0]       m_out_blue;
    logic [CH_BITS-1:0]       m_out_matte;

    int mismatch_count;
    int pixels_in_flight;
    int cycles     = 0;
    int send_idle  = 0;
    int recv_stall = 0;

    // idle modes: none, sender only, receiver only, both
    int send_idle_pct [4] = '{0, 69, 0, 35};
    int recv_stall_pct [4] = '{0, 0, 69, 35};

    // 32'hRRGGBBMM
    logic [31:0] directed_pixels [NUM_DIRECTED] = '{
        32'h00_00_00_00, 32'hFF_FF_FF_FF, 32'hFF_80_01_00, 32'hC8_64_32_64,
        32'h01_01_01_01, 32'h00_00_00_FF, 32'hFF_00_00_01, 32'h80_40_20_FF,
        32'h0A_14_1E_28, 32'h00_00_00_01, 32'hFE_FE_FE_FE, 32'h55_AA_FF_00
    };

    rgba_channel_mixer #(
        .CHANNEL_BITS  (CH_BITS),
        .COEF_FRAC_BITS(FRAC_BITS)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_red   (s_in_red),
        .s_in_green (s_in_green),
        .s_in_blue  (s_in_blue),
        .s_in_matte (s_in_matte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_red  (m_out_red),
        .m_out_green(m_out_green),
        .m_out_blue (m_out_blue),
        .m_out_matte(m_out_matte)
    );

    rgbacm_mix_checker #(
        .CHANNEL_BITS  (CH_BITS),
        .COEF_FRAC_BITS(FRAC_BITS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_red   (s_in_red),
        .s_in_green (s_in_green),
        .s_in_blue  (s_in_blue),
        .s_in_matte (s_in_matte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_red  (m_out_red),
        .m_out_green(m_out_green),
        .m_out_blue (m_out_blue),
        .m_out_matte(m_out_matte),
        .mismatches (mismatch_count),
        .in_flight  (pixels_in_flight)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("rgba_channel_mixer: mismatch");
            $finish;
        end
    end

    task automatic push_pixel(input logic [CH_BITS-1:0] r, g, b, a);
        if ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle);
        end
        s_valid    <= 1'b1;
        s_in_red   <= r;
        s_in_green <= g;
        s_in_blue  <= b;
        s_in_matte <= a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // hold off the sender until every request has come back out
    task automatic wait_empty();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pixels_in_flight != 0);
    endtask

    task automatic load_matrix(input logic [REG_BITS-1:0] rows [NUM_REGS]);
        for (int i = REG_RED_RG; i <= REG_MATTE_BM; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_ADDR_BITS'(i);
            cfg_wdata <= rows[i];
            @(posedge aclk);
        end
        // an unmapped index must leave the matrix alone
        cfg_index <= CFG_ADDR_BITS'($urandom_range(NUM_REGS, (1 << CFG_ADDR_BITS) - 1));
        cfg_wdata <= $urandom;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [REG_BITS-1:0] unit_coef_pair();
        logic [COEF_BITS-1:0] lo, hi;
        lo = COEF_BITS'($urandom_range(0, 1 << FRAC_BITS));
        hi = COEF_BITS'($urandom_range(0, 1 << FRAC_BITS));
        return {hi, lo};
    endfunction

    task automatic push_random_pixel();
        logic [CH_BITS-1:0] r, g, b, a;
        int sel;
        sel = $urandom_range(0, 9);
        r = CH_BITS'($urandom);
        g = CH_BITS'($urandom);
        b = CH_BITS'($urandom);
        a = CH_BITS'($urandom);
        case (sel)
            0: a = '0;
            1: a = '1;
            2, 3: ;
            default: begin
                // properly premultiplied: colors never exceed alpha
                a = CH_BITS'($urandom_range(1, (1 << CH_BITS) - 1));
                r = CH_BITS'($urandom_range(0, a));
                g = CH_BITS'($urandom_range(0, a));
                b = CH_BITS'($urandom_range(0, a));
            end
        endcase
        push_pixel(r, g, b, a);
    endtask

    initial begin
        logic [REG_BITS-1:0] rows [NUM_REGS];
        matrix_kind_e kind;
        int mode;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corners, first on the reset identity, then with every coefficient near 2
        foreach (directed_pixels[i])
            push_pixel(directed_pixels[i][31:24], directed_pixels[i][23:16],
                       directed_pixels[i][15:8], directed_pixels[i][7:0]);
        wait_empty();
        foreach (rows[i]) rows[i] = '1;
        load_matrix(rows);
        foreach (directed_pixels[i])
            push_pixel(directed_pixels[i][31:24], directed_pixels[i][23:16],
                       directed_pixels[i][15:8], directed_pixels[i][7:0]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_empty();
            kind = matrix_kind_e'(p % NUM_KINDS);
            foreach (rows[i]) rows[i] = '0;
            case (kind)
                MAT_ZERO: ;
                MAT_FULL:       foreach (rows[i]) rows[i] = '1;
                MAT_RANDOM:     foreach (rows[i]) rows[i] = $urandom;
                MAT_UNIT_RANGE: foreach (rows[i]) rows[i] = unit_coef_pair();
                MAT_IDENTITY:   foreach (rows[i]) rows[i] = REG_RESET[i];
                MAT_SWAP_RB: begin
                    rows[REG_RED_BM]   = COEF_ONE;
                    rows[REG_GREEN_RG] = COEF_ONE << COEF_BITS;
                    rows[REG_BLUE_RG]  = COEF_ONE;
                    rows[REG_MATTE_BM] = COEF_ONE << COEF_BITS;
                end
            endcase
            load_matrix(rows);
            mode = p % 4;
            send_idle  = send_idle_pct[mode];
            recv_stall = recv_stall_pct[mode];
            repeat (PHASE_ITEMS) push_random_pixel();
        end

        wait_empty();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pixels_in_flight == 0)
            $display("rgba_channel_mixer: match");
        else
            $display("rgba_channel_mixer: mismatch");
        $finish;
    end

endmodule
